FILE: design/fab_pkg.sv
// Shared types, codes and constants of the frame bitmap allocator.
// Used by the controller, the datapath, the top level and the checker.
package fab_pkg;

    localparam int FRAME_W          = 12;
    localparam int WORD_W           = 32;
    localparam int BIT_IDX_W        = 5;
    localparam int WORD_IDX_W       = FRAME_W - BIT_IDX_W;
    localparam int FIELD_WORDS      = 128;
    localparam int BITMAP_WORDS_DEF = 128;
    localparam int CFG_W            = 8;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 16;
    localparam int S_TUSER_W        = 1;
    localparam int M_TUSER_W        = 2;

    localparam logic [WORD_W-1:0] FULL_WORD         = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]  FRAME_WORDS_RESET = 8'd128;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MAPPED  = 2'd1,
        STATUS_NO_FREE = 2'd2,
        STATUS_NOTHING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    scan;
        logic    free_rd;
        logic    free_wr;
        logic    status_we;
        status_t status_val;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic in_is_free;
        logic in_pf_zero;
        logic in_word_in_range;
        logic limit_zero;
        logic found;
        logic exhausted;
        logic out_free;
    } sts_t;

endpackage

FILE: design/fab_ctrl.sv
// Controller of the frame bitmap allocator: sequences accept, scan, free and output.
// Depends on fab_pkg; drives the datapath through cmd_t and reads sts_t.
module fab_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  fab_pkg::sts_t sts,
    output fab_pkg::cmd_t cmd
);
    import fab_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!sts.in_is_free) begin
                        if (!sts.in_pf_zero || sts.limit_zero) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (!sts.in_pf_zero && sts.in_word_in_range) begin
                        state_next = S_FREE_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (sts.found || sts.exhausted) begin
                    state_next = S_DONE;
                end
            end
            S_FREE_RD: state_next = S_FREE_WR;
            S_FREE_WR: state_next = S_DONE;
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept    = 1'b1;
                    cmd.status_we = 1'b1;
                    if (!sts.in_is_free) begin
                        if (!sts.in_pf_zero) begin
                            cmd.status_val = STATUS_MAPPED;
                        end else if (sts.limit_zero) begin
                            cmd.status_val = STATUS_NO_FREE;
                        end else begin
                            cmd.status_val = STATUS_OK;
                        end
                    end else if (sts.in_pf_zero) begin
                        cmd.status_val = STATUS_NOTHING;
                    end else begin
                        cmd.status_val = STATUS_OK;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.found) begin
                    cmd.status_we  = 1'b1;
                    cmd.status_val = STATUS_OK;
                end else if (sts.exhausted) begin
                    cmd.status_we  = 1'b1;
                    cmd.status_val = STATUS_NO_FREE;
                end
            end
            S_FREE_RD: cmd.free_rd = 1'b1;
            S_FREE_WR: cmd.free_wr = 1'b1;
            S_DONE:    cmd.load_out = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/fab_datapath.sv
// Datapath of the frame bitmap allocator: bitmap memory, scan counter and result registers.
// Depends on fab_pkg; commanded by fab_ctrl through cmd_t, reports through sts_t.
module fab_datapath #(
    parameter int BITMAP_WORDS = fab_pkg::BITMAP_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fab_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [fab_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          cfg_wr_en,
    input  logic [fab_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fab_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [fab_pkg::M_TUSER_W-1:0] m_tuser,
    input  fab_pkg::cmd_t                 cmd,
    output fab_pkg::sts_t                 sts
);
    import fab_pkg::*;

    localparam int DEPTH = (BITMAP_WORDS < FIELD_WORDS) ? BITMAP_WORDS : FIELD_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

    function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    logic [WORD_W-1:0]    mem [DEPTH];
    logic [DEPTH-1:0]     entry_vld_reg, entry_vld_next;
    logic [CFG_W-1:0]     frame_words_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     limit_reg;
    logic                 chk_vld_reg, chk_vld_next;
    logic [AW-1:0]        chk_idx_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    op_t                  op_reg;
    logic [FRAME_W-1:0]   pf_reg;
    logic                 kern_reg;
    logic                 wr_reg;
    status_t              status_reg;
    logic [FRAME_W-1:0]   found_frame_reg;
    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic                 out_present_reg;
    logic                 out_rw_reg;
    logic                 out_user_reg;

    logic [FRAME_W-1:0]   in_pf;
    logic [CFG_W-1:0]     limit8;
    logic                 issue;
    logic [WORD_W-1:0]    cur_word;
    logic                 word_full;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [AW-1:0]        pf_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 alloc_ok;

    assign in_pf     = s_tdata[FRAME_W-1:0];
    assign limit8    = (frame_words_reg > DEPTH_C) ? DEPTH_C : frame_words_reg;
    assign issue     = cnt_reg < limit_reg;
    assign cur_word  = rd_vld_reg ? rd_data_reg : '0;
    assign word_full = cur_word == FULL_WORD;
    assign bit_pos   = first_zero(cur_word);
    assign pf_addr   = pf_reg[BIT_IDX_W +: AW];

    always_comb begin
        sts.in_is_free       = s_tuser[0] == OP_FREE;
        sts.in_pf_zero       = in_pf == '0;
        sts.in_word_in_range = {1'b0, in_pf[FRAME_W-1:BIT_IDX_W]} < DEPTH_C;
        sts.limit_zero       = frame_words_reg == '0;
        sts.found            = chk_vld_reg && !word_full;
        sts.exhausted        = chk_vld_reg && word_full && !issue;
        sts.out_free         = !out_vld_reg || m_tready;
    end

    always_comb begin
        rd_en   = cmd.free_rd || (cmd.scan && issue);
        rd_addr = cmd.free_rd ? pf_addr : cnt_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = chk_idx_reg;
        wr_data = cur_word | (WORD_W'(1) << bit_pos);
        if (cmd.scan && sts.found) begin
            wr_en = 1'b1;
        end else if (cmd.free_wr) begin
            wr_en   = 1'b1;
            wr_addr = pf_addr;
            wr_data = cur_word & ~(WORD_W'(1) << pf_reg[BIT_IDX_W-1:0]);
        end
    end

    always_comb begin
        entry_vld_next = entry_vld_reg;
        if (wr_en) begin
            entry_vld_next[wr_addr] = 1'b1;
        end
        cnt_next     = cnt_reg;
        chk_vld_next = chk_vld_reg;
        if (cmd.accept) begin
            cnt_next     = '0;
            chk_vld_next = 1'b0;
        end else if (cmd.scan) begin
            chk_vld_next = issue;
            if (issue) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        out_vld_next = out_vld_reg;
        if (cmd.load_out) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_vld_reg   <= '0;
            frame_words_reg <= FRAME_WORDS_RESET;
            cnt_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
        end else begin
            entry_vld_reg <= entry_vld_next;
            if (cfg_wr_en) begin
                frame_words_reg <= cfg_wr_data;
            end
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= entry_vld_reg[rd_addr];
        end
    end

    assign alloc_ok = (op_reg == OP_ALLOC) && (status_reg == STATUS_OK);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= op_t'(s_tuser[0]);
            pf_reg    <= in_pf;
            kern_reg  <= s_tdata[FRAME_W];
            wr_reg    <= s_tdata[FRAME_W+1];
            limit_reg <= CNT_W'(limit8);
        end
        if (cmd.scan && issue) begin
            chk_idx_reg <= cnt_reg[AW-1:0];
        end
        if (cmd.status_we) begin
            status_reg <= cmd.status_val;
        end
        if (cmd.scan && sts.found) begin
            found_frame_reg <= FRAME_W'({chk_idx_reg, bit_pos});
        end
        if (cmd.load_out) begin
            out_status_reg  <= status_reg;
            out_present_reg <= alloc_ok;
            out_rw_reg      <= alloc_ok && wr_reg;
            out_user_reg    <= alloc_ok && !kern_reg;
            if (alloc_ok) begin
                out_frame_reg <= found_frame_reg;
            end else if (status_reg == STATUS_MAPPED) begin
                out_frame_reg <= pf_reg;
            end else begin
                out_frame_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_user_reg, out_rw_reg, out_present_reg, out_frame_reg};

endmodule

FILE: design/frame_bitmap_allocator.sv
// Frame bitmap allocator: first-fit allocation and freeing of frames in a word bitmap.
// Flow: an allocation reads the bitmap word by word from word 0 until one holds a free frame,
// or through all configured words if none does; a free reads and rewrites its word; others go straight to the result.
// Throughput: one request at a time; the next is taken once the result sits in the output
// register, set by the word-by-word scan over the bitmap memory (one read port, one write port).
// Reset: synchronous; all frames free at once through per-word valid flags, frame_words 128.
module frame_bitmap_allocator #(
    parameter int BITMAP_WORDS = fab_pkg::BITMAP_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // page_frame[11:0], is_kernel[12], writable[13], zero[15:14]
    input  logic [fab_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [fab_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // frame[11:0], present[12], rw_flag[13], user_flag[14], zero[15]
    output logic [fab_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [fab_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [fab_pkg::CFG_W-1:0]     cfg_wr_data
);
    import fab_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fab_datapath #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: design/fab_checker.sv
// Port-level checker of the frame bitmap allocator, bound to the top level.
// Depends on fab_pkg for the status codes.
module fab_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fab_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fab_pkg::M_TUSER_W-1:0] m_tuser
);
    import fab_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_present_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[FRAME_W] |-> m_tuser == STATUS_OK)
        else $error("present flag without a successful allocation");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_NO_FREE || m_tuser == STATUS_NOTHING) |-> m_tdata == '0)
        else $error("failed request carries nonzero data");

endmodule

bind frame_bitmap_allocator fab_checker u_fab_checker (.*);
